// File: hdl/ctpg_pkg.sv
// Shared types and constants of the calibration test-pattern generator.
// No dependencies; every other file imports this package.
package ctpg_pkg;

	localparam int COORD_BITS    = 12;
	localparam int PHASE_BITS    = 7;
	localparam int COLOR_BITS    = 8;
	localparam int EXT_BITS      = COORD_BITS + 2;
	localparam int CFG_ADDR_BITS = 2;
	localparam int IN_DATA_BITS  = 8;
	localparam int OUT_FIELD_BITS = 3 * COLOR_BITS + 2 * COORD_BITS;
	localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	typedef logic [COORD_BITS-1:0]    coord_t;
	typedef logic [PHASE_BITS-1:0]    phase_t;
	typedef logic [COLOR_BITS-1:0]    color_t;
	typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

	localparam cfg_addr_t CFG_FRAME_WIDTH  = CFG_ADDR_BITS'(0);
	localparam cfg_addr_t CFG_FRAME_HEIGHT = CFG_ADDR_BITS'(1);

	localparam coord_t RESET_WIDTH  = COORD_BITS'(640);
	localparam coord_t RESET_HEIGHT = COORD_BITS'(480);

	localparam phase_t PHASE_LAST = PHASE_BITS'(99);
	localparam phase_t PHASE_HALF = PHASE_BITS'(50);

	localparam color_t COLOR_FULL = COLOR_BITS'(255);
	localparam color_t COLOR_BG   = COLOR_BITS'(200);
	localparam color_t COLOR_MID  = COLOR_BITS'(100);
	localparam color_t COLOR_DARK = COLOR_BITS'(50);

	typedef struct packed {
		coord_t column;
		coord_t row;
		phase_t column_phase;
		phase_t row_phase;
		logic   line_end;
		logic   frame_end;
	} pos_t;

	typedef struct packed {
		color_t blue;
		color_t green;
		color_t red;
	} rgb_t;

endpackage

// File: hdl/ctpg_raster.sv
// Raster position counters: column, row and their modulo-100 phases.
// Depends on ctpg_pkg.
module ctpg_raster (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            frame_start,
	input  ctpg_pkg::coord_t frame_width,
	input  ctpg_pkg::coord_t frame_height,
	output ctpg_pkg::pos_t   pos
);
	import ctpg_pkg::*;

	coord_t column_q, row_q;
	phase_t column_phase_q, row_phase_q;

	// restart applies before this pixel is produced
	always_comb begin
		pos.column       = frame_start ? '0 : column_q;
		pos.row          = frame_start ? '0 : row_q;
		pos.column_phase = frame_start ? '0 : column_phase_q;
		pos.row_phase    = frame_start ? '0 : row_phase_q;
		pos.line_end     = ({1'b0, pos.column} + (COORD_BITS+1)'(1)) >= {1'b0, frame_width};
		pos.frame_end    = pos.line_end &&
			(({1'b0, pos.row} + (COORD_BITS+1)'(1)) >= {1'b0, frame_height});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q       <= '0;
			row_q          <= '0;
			column_phase_q <= '0;
			row_phase_q    <= '0;
		end else if (advance) begin
			if (pos.line_end) begin
				column_q       <= '0;
				column_phase_q <= '0;
				if (pos.frame_end) begin
					row_q       <= '0;
					row_phase_q <= '0;
				end else begin
					row_q       <= pos.row + 1'b1;
					row_phase_q <= (pos.row_phase == PHASE_LAST) ? '0 : pos.row_phase + 1'b1;
				end
			end else begin
				column_q       <= pos.column + 1'b1;
				column_phase_q <= (pos.column_phase == PHASE_LAST) ? '0 :
					pos.column_phase + 1'b1;
				row_q          <= pos.row;
				row_phase_q    <= pos.row_phase;
			end
		end
	end

endmodule

// File: hdl/ctpg_color.sv
// Pattern color for one raster position: grid, center cross, corner squares.
// Depends on ctpg_pkg.
module ctpg_color (
	input  ctpg_pkg::pos_t   pos,
	input  ctpg_pkg::coord_t frame_width,
	input  ctpg_pkg::coord_t frame_height,
	output ctpg_pkg::rgb_t   rgb
);
	import ctpg_pkg::*;

	localparam logic [EXT_BITS-1:0] D10 = EXT_BITS'(10);
	localparam logic [EXT_BITS-1:0] D30 = EXT_BITS'(30);
	localparam logic [EXT_BITS-1:0] D50 = EXT_BITS'(50);

	function automatic logic near_band(input logic [EXT_BITS-1:0] v,
			input logic [EXT_BITS-1:0] size);
		return (v >= D10) && (v < D30) && (v < size);
	endfunction

	// v >= max(10, size-30) and v < size-10, kept free of negatives
	function automatic logic far_band(input logic [EXT_BITS-1:0] v,
			input logic [EXT_BITS-1:0] size);
		return (v >= D10) && (v + D30 >= size) && (v + D10 < size);
	endfunction

	logic [EXT_BITS-1:0] x, y, w, h, cx, cy;
	logic on_cross, nx, ny, fx, fy;

	always_comb begin
		x  = EXT_BITS'(pos.column);
		y  = EXT_BITS'(pos.row);
		w  = EXT_BITS'(frame_width);
		h  = EXT_BITS'(frame_height);
		cx = EXT_BITS'(frame_width >> 1);
		cy = EXT_BITS'(frame_height >> 1);
		on_cross = ((y == cy) && (x + D50 >= cx) && (x <= cx + D50) && (x < w)) ||
			((x == cx) && (y + D50 >= cy) && (y <= cy + D50) && (y < h));
		nx = near_band(x, w);
		ny = near_band(y, h);
		fx = far_band(x, w);
		fy = far_band(y, h);

		rgb = '{blue: COLOR_BG, green: COLOR_BG, red: COLOR_BG};
		if (pos.column_phase == '0 || pos.column_phase == PHASE_HALF ||
				pos.row_phase == '0 || pos.row_phase == PHASE_HALF) begin
			rgb = '{blue: COLOR_MID, green: COLOR_MID, red: COLOR_MID};
		end
		if (pos.column_phase == '0 || pos.row_phase == '0) begin
			rgb = '{blue: COLOR_DARK, green: COLOR_DARK, red: COLOR_DARK};
		end
		if (on_cross) begin
			rgb = '{blue: '0, green: '0, red: COLOR_FULL};
		end
		if (nx && ny) begin
			rgb = '{blue: COLOR_FULL, green: '0, red: '0};
		end
		if (fx && ny) begin
			rgb = '{blue: '0, green: COLOR_FULL, red: '0};
		end
		if (nx && fy) begin
			rgb = '{blue: '0, green: COLOR_FULL, red: COLOR_FULL};
		end
		if (fx && fy) begin
			rgb = '{blue: COLOR_FULL, green: '0, red: COLOR_FULL};
		end
	end

endmodule

// File: hdl/calibration_test_pattern_gen_unit.sv
// A pixel appears on the master side in the cycle after its tick transfers.
// Throughput: one pixel per cycle while the master side takes each pixel; the single result
// register frees up in the same cycle its pixel is taken, so ticks flow back to back.
// Reset (arst_n low, asynchronous): raster at (0,0), phases zero, output empty,
// frame size 640 x 480.
module calibration_test_pattern_gen_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [ctpg_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // [0] frame_start
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// red, green, blue, column, row from bit 0 up
	output logic [ctpg_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
	output logic                                m_axis_tlast,  // line_end
	output logic                                m_axis_tuser,  // frame_end
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  ctpg_pkg::cfg_addr_t                 cfg_addr,
	input  ctpg_pkg::coord_t                    cfg_data
);
	import ctpg_pkg::*;

	coord_t frame_width_q, frame_height_q;
	logic   accept;
	pos_t   pos;
	rgb_t   rgb;

	logic                     m_valid_q;
	logic [OUT_DATA_BITS-1:0] m_data_q;
	logic                     m_last_q, m_user_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_WIDTH;
			frame_height_q <= RESET_HEIGHT;
		end else if (cfg_valid) begin
			case (cfg_addr)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ctpg_raster u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.frame_start  (s_axis_tdata[0]),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pos          (pos)
	);

	ctpg_color u_color (
		.pos          (pos),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.rgb          (rgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// hold the pixel until its transfer completes
	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= OUT_DATA_BITS'({pos.row, pos.column, rgb.blue, rgb.green, rgb.red});
			m_last_q <= pos.line_end;
			m_user_q <= pos.frame_end;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// File: hdl/ctpg_checker.sv
// Port-level checks of the test-pattern generator, bound to the top level.
// Depends on ctpg_pkg and calibration_test_pattern_gen_unit.
module ctpg_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic [ctpg_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [ctpg_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
	input logic                               m_axis_tlast,
	input logic                               m_axis_tuser
);
	import ctpg_pkg::*;

	localparam int COL_LO = 3 * COLOR_BITS;

	// frame end only on the last pixel of a line
	a_frame_end_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast || !m_axis_tuser))
		else $error("frame end without line end");

	// an empty output stage never stalls the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// every tick transfer yields a pixel in the next cycle
	a_pixel_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
		else $error("no pixel after tick");

	// restart puts the pixel at the origin
	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) |=>
		(m_axis_tdata[COL_LO + 2*COORD_BITS - 1 : COL_LO] == '0))
		else $error("restart pixel not at origin");

	// a stalled pixel holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
		$stable(m_axis_tuser)))
		else $error("stalled pixel changed");

endmodule

bind calibration_test_pattern_gen_unit ctpg_checker u_ctpg_checker (.*);
